>>> sv/spfd_pkg.sv
// Shared types and constants of the stereo ping-pong feedback delay.
package spfd_pkg;

  // Sample and configuration widths
  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned CFG_W     = 19;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LEN_CFG_W = 19;
  localparam int unsigned FB_W      = 16;
  localparam int unsigned GAIN_W    = 17;
  localparam int unsigned PAN_W     = 17;

  // Shared multiplier bank: 18-bit signed coefficient times one sample
  localparam int unsigned NUM_MUL = 4;
  localparam int unsigned MUL_A_W = 18;
  localparam int unsigned PROD_W  = MUL_A_W + SAMPLE_W;

  // Output queue depth and the width of the transaction credit count
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = 2;
  localparam int unsigned CREDIT_W  = 3;

  // Fixed-point constants
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;
  localparam logic signed [MUL_A_W-1:0] PAN_ONE = 18'sd32768;

  // Register reset values
  localparam logic [LEN_CFG_W-1:0] DELAY_LENGTH_RST  = 19'd24000;
  localparam logic [FB_W-1:0]      FEEDBACK_GAIN_RST = 16'd32768;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_LENGTH  = 3'd0,
    CFG_FEEDBACK_GAIN = 3'd1,
    CFG_DRY_GAIN      = 3'd2,
    CFG_WET_GAIN      = 3'd3,
    CFG_BYPASS        = 3'd4,
    CFG_PING_PONG     = 3'd5,
    CFG_PAN_AMOUNT    = 3'd6
  } cfg_idx_e;

  // One stereo sample pair
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] right;
    logic signed [SAMPLE_W-1:0] left;
  } pair_t;

  // Operands of one multiplier
  typedef struct packed {
    logic signed [MUL_A_W-1:0]  a;
    logic signed [SAMPLE_W-1:0] b;
  } mul_op_t;

endpackage

>>> sv/spfd_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module spfd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/spfd_mul_bank.sv
// Bank of four signed multipliers shared by the two phases of each sample pair.
module spfd_mul_bank (
  input  spfd_pkg::mul_op_t                  op_i   [spfd_pkg::NUM_MUL],
  output logic signed [spfd_pkg::PROD_W-1:0] prod_o [spfd_pkg::NUM_MUL]
);

  // Extend both operands to the full product width, then multiply
  for (genvar i = 0; i < spfd_pkg::NUM_MUL; i++) begin : g_mul
    assign prod_o[i] = spfd_pkg::PROD_W'($signed(op_i[i].a))
                     * spfd_pkg::PROD_W'($signed(op_i[i].b));
  end

endmodule

>>> sv/spfd_out_fifo.sv
// Small output queue that holds finished sample pairs until the sink takes them.
module spfd_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  spfd_pkg::pair_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output spfd_pkg::pair_t data_o
);

  spfd_pkg::pair_t                      entry_q [spfd_pkg::OUT_DEPTH];
  logic [spfd_pkg::OUT_PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [spfd_pkg::OUT_PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [spfd_pkg::CREDIT_W-1:0]        count_q, count_d;
  logic                                 pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o & ready_i;
  assign data_o  = entry_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + spfd_pkg::CREDIT_W'(push_i) - spfd_pkg::CREDIT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed pair
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> sv/stereo_pingpong_feedback_delay.sv
// Stereo ping-pong feedback delay: top level with pipeline, stores and config registers.
//
// The block takes one stereo pair (signed Q1.23) at a time and returns one output
// pair for each pair accepted. It takes no new pair while the last one is in the
// first stage, since the four multipliers are shared: the first stage forms the dry
// and pan products, the second the feedback and wet products on the delayed pair read
// from the left and right stores. Results wait in a four-entry output queue, so
// input keeps flowing while the sink stalls, up to four outstanding pairs. After
// reset, and when a bypass pair arrives after the stores have been written, a
// clearing pass zeroes both stores, one entry per cycle; no pair is accepted
// during it, while configuration writes are taken as ever.
module stereo_pingpong_feedback_delay #(
  parameter int unsigned MAX_DELAY = 262144
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream; tdata: left_in [23:0], right_in [47:24]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [2*spfd_pkg::SAMPLE_W-1:0] s_axis_tdata,
  // Output stream; tdata: left_out [23:0], right_out [47:24]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [2*spfd_pkg::SAMPLE_W-1:0] m_axis_tdata,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [spfd_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [spfd_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int unsigned ADDR_W = $clog2(MAX_DELAY);
  localparam int unsigned LEN_W  = $clog2(MAX_DELAY + 1);
  localparam int unsigned CMP_W  = (LEN_W > spfd_pkg::LEN_CFG_W) ? LEN_W : spfd_pkg::LEN_CFG_W;
  localparam int unsigned SW     = spfd_pkg::SAMPLE_W;
  localparam int unsigned PW     = spfd_pkg::PROD_W;
  localparam int unsigned AW     = spfd_pkg::MUL_A_W;
  localparam int unsigned SUM_W  = PW + 1;
  localparam int unsigned SAT_W  = SUM_W - 15;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((1 << (SW - 1)) - 1);
  localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_DELAY - 1);

  // Clamp a wide sum to the signed sample range
  function automatic logic signed [SW-1:0] sat_sample(input logic signed [SAT_W-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [spfd_pkg::LEN_CFG_W-1:0]    delay_length_q;
  logic [spfd_pkg::FB_W-1:0]         feedback_gain_q;
  logic [spfd_pkg::GAIN_W-1:0]       dry_gain_q;
  logic [spfd_pkg::GAIN_W-1:0]       wet_gain_q;
  logic                              bypass_q;
  logic                              ping_pong_q;
  logic signed [spfd_pkg::PAN_W-1:0] pan_amount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_length_q  <= spfd_pkg::DELAY_LENGTH_RST;
      feedback_gain_q <= spfd_pkg::FEEDBACK_GAIN_RST;
      dry_gain_q      <= spfd_pkg::GAIN_ONE;
      wet_gain_q      <= spfd_pkg::GAIN_ONE;
      bypass_q        <= 1'b0;
      ping_pong_q     <= 1'b0;
      pan_amount_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        spfd_pkg::CFG_DELAY_LENGTH:  delay_length_q  <= cfg_data_i[spfd_pkg::LEN_CFG_W-1:0];
        spfd_pkg::CFG_FEEDBACK_GAIN: feedback_gain_q <= cfg_data_i[spfd_pkg::FB_W-1:0];
        spfd_pkg::CFG_DRY_GAIN:      dry_gain_q      <= cfg_data_i[spfd_pkg::GAIN_W-1:0];
        spfd_pkg::CFG_WET_GAIN:      wet_gain_q      <= cfg_data_i[spfd_pkg::GAIN_W-1:0];
        spfd_pkg::CFG_BYPASS:        bypass_q        <= cfg_data_i[0];
        spfd_pkg::CFG_PING_PONG:     ping_pong_q     <= cfg_data_i[0];
        spfd_pkg::CFG_PAN_AMOUNT:    pan_amount_q    <= $signed(cfg_data_i[spfd_pkg::PAN_W-1:0]);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Derived coefficients
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0]           len_ext;
  logic [LEN_W-1:0]           len_eff;
  logic [spfd_pkg::GAIN_W-1:0] dry_eff, wet_eff;
  logic signed [AW-1:0]       dry_op, wet_op, fb_op, pan_ext, pan_mag, pan_mag_c, pan_factor;
  logic                       pan_neg;

  always_comb begin
    // Delay length: zero acts as one, beyond the store depth saturates
    len_ext = CMP_W'(delay_length_q);
    if (len_ext == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_ext > CMP_W'(MAX_DELAY)) begin
      len_eff = LEN_W'(MAX_DELAY);
    end else begin
      len_eff = len_ext[LEN_W-1:0];
    end

    // Gains saturate at one; bypass forces unity dry and no wet
    dry_eff = (dry_gain_q > spfd_pkg::GAIN_ONE) ? spfd_pkg::GAIN_ONE : dry_gain_q;
    wet_eff = (wet_gain_q > spfd_pkg::GAIN_ONE) ? spfd_pkg::GAIN_ONE : wet_gain_q;
    if (bypass_q) begin
      dry_eff = spfd_pkg::GAIN_ONE;
      wet_eff = '0;
    end
    dry_op = $signed({1'b0, dry_eff});
    wet_op = $signed({1'b0, wet_eff});
    fb_op  = $signed({2'b00, feedback_gain_q});

    // Pan: magnitude clamped to one, factor is one minus magnitude in ping-pong mode, else one
    pan_neg    = pan_amount_q[spfd_pkg::PAN_W-1];
    pan_ext    = AW'(pan_amount_q);
    pan_mag    = pan_neg ? -pan_ext : pan_ext;
    pan_mag_c  = (pan_mag > spfd_pkg::PAN_ONE) ? spfd_pkg::PAN_ONE : pan_mag;
    pan_factor = ping_pong_q ? spfd_pkg::PAN_ONE - pan_mag_c : spfd_pkg::PAN_ONE;
  end

  // ---------------------------------------------------------------------------
  // Position, clearing pass and input acceptance
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]             pos_q, pos_d, rd_pos;
  logic [LEN_W-1:0]              pos_inc;
  logic                          clr_active_q, clr_active_d;
  logic [ADDR_W-1:0]             clr_addr_q, clr_addr_d;
  logic                          dirty_q, dirty_d;
  logic [spfd_pkg::CREDIT_W-1:0] inflight_q, inflight_d;
  logic                          accept, pop;
  logic                          s1_valid_q;

  assign s_axis_tready = !s1_valid_q && !clr_active_q
                      && (inflight_q < spfd_pkg::CREDIT_W'(spfd_pkg::OUT_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_comb begin
    // Restart a position left beyond a shortened length, then advance and wrap
    rd_pos  = (LEN_W'(pos_q) >= len_eff) ? '0 : pos_q;
    pos_inc = LEN_W'(rd_pos) + LEN_W'(1);
    pos_d   = pos_q;
    if (accept && !bypass_q) begin
      pos_d = (pos_inc >= len_eff) ? '0 : pos_inc[ADDR_W-1:0];
    end

    // Sweep the stores; start a sweep on a bypass pair after stores were written
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    dirty_d      = dirty_q;
    if (clr_active_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == LAST_ADDR) begin
        clr_active_d = 1'b0;
        clr_addr_d   = '0;
      end
    end
    if (accept) begin
      if (bypass_q) begin
        if (dirty_q) begin
          clr_active_d = 1'b1;
          dirty_d      = 1'b0;
        end
      end else begin
        dirty_d = 1'b1;
      end
    end

    inflight_d = inflight_q + spfd_pkg::CREDIT_W'(accept) - spfd_pkg::CREDIT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      dirty_q      <= 1'b0;
      inflight_q   <= '0;
    end else begin
      pos_q        <= pos_d;
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
      dirty_q      <= dirty_d;
      inflight_q   <= inflight_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline stages
  // ---------------------------------------------------------------------------
  logic                  s2_valid_q, s3_valid_q;
  spfd_pkg::pair_t       s1_in_q, s2_in_q, s3_in_q;
  logic [ADDR_W-1:0]     s1_addr_q, s2_addr_q, s3_addr_q;
  logic signed [PW-1:0]  s2_dry_l_q, s2_dry_r_q, s2_att_q;
  logic signed [PW-1:0]  s3_dry_l_q, s3_dry_r_q, s3_att_q;
  logic signed [PW-1:0]  s3_fb_l_q, s3_fb_r_q, s3_wet_l_q, s3_wet_r_q;
  logic                  fwd_q, fwd_d;
  spfd_pkg::pair_t       fwd_pair_q, wr_pair;
  logic                  pipe_we;
  logic [SW-1:0]         rd_left, rd_right;
  logic signed [SW-1:0]  dly_l, dly_r;
  spfd_pkg::mul_op_t     mul_op [spfd_pkg::NUM_MUL];
  logic signed [PW-1:0]  mul_prod [spfd_pkg::NUM_MUL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      fwd_q      <= fwd_d;
    end
  end

  // Capture payload as each stage advances
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_in_q   <= s_axis_tdata;
      s1_addr_q <= rd_pos;
    end
    if (s1_valid_q) begin
      s2_in_q    <= s1_in_q;
      s2_addr_q  <= s1_addr_q;
      s2_dry_l_q <= mul_prod[0];
      s2_dry_r_q <= mul_prod[1];
      s2_att_q   <= mul_prod[2];
    end
    if (s2_valid_q) begin
      s3_in_q    <= s2_in_q;
      s3_addr_q  <= s2_addr_q;
      s3_dry_l_q <= s2_dry_l_q;
      s3_dry_r_q <= s2_dry_r_q;
      s3_att_q   <= s2_att_q;
      s3_fb_l_q  <= mul_prod[0];
      s3_fb_r_q  <= mul_prod[1];
      s3_wet_l_q <= mul_prod[2];
      s3_wet_r_q <= mul_prod[3];
    end
    fwd_pair_q <= wr_pair;
  end

  // Forward a store write that lands on the entry read at the same edge
  assign pipe_we = s3_valid_q && !bypass_q;
  assign fwd_d   = s1_valid_q && pipe_we && (s1_addr_q == s3_addr_q);
  assign dly_l   = fwd_q ? fwd_pair_q.left  : $signed(rd_left);
  assign dly_r   = fwd_q ? fwd_pair_q.right : $signed(rd_right);

  // Share the multipliers: dry and pan products first, then feedback and wet
  always_comb begin
    if (s2_valid_q) begin
      mul_op[0] = '{a: fb_op,  b: dly_l};
      mul_op[1] = '{a: fb_op,  b: dly_r};
      mul_op[2] = '{a: wet_op, b: dly_l};
      mul_op[3] = '{a: wet_op, b: dly_r};
    end else begin
      mul_op[0] = '{a: dry_op,     b: s1_in_q.left};
      mul_op[1] = '{a: dry_op,     b: s1_in_q.right};
      mul_op[2] = '{a: pan_factor, b: pan_neg ? s1_in_q.right : s1_in_q.left};
      mul_op[3] = '{a: '0,         b: '0};
    end
  end

  spfd_mul_bank u_mul_bank (
    .op_i   (mul_op),
    .prod_o (mul_prod)
  );

  // ---------------------------------------------------------------------------
  // Final stage: round, sum and saturate store and output samples
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0]    att_sum, fb_l_sum, fb_r_sum;
  logic signed [SUM_W-1:0] out_l_sum, out_r_sum;
  logic signed [SW-1:0]    att_s, wr_in_l, wr_in_r;
  logic signed [PW-17:0]   fb_l_rnd, fb_r_rnd, fb_to_l, fb_to_r;
  spfd_pkg::pair_t         out_pair;

  always_comb begin
    // Pan attenuation, Q1.15 rounding
    att_sum = s3_att_q + PW'(16384);
    att_s   = $signed(att_sum[SW+14:15]);
    wr_in_l = (ping_pong_q && !pan_neg) ? att_s : s3_in_q.left;
    wr_in_r = (ping_pong_q &&  pan_neg) ? att_s : s3_in_q.right;

    // Feedback products, Q0.16 rounding, crossed in ping-pong mode
    fb_l_sum = s3_fb_l_q + PW'(32768);
    fb_r_sum = s3_fb_r_q + PW'(32768);
    fb_l_rnd = $signed(fb_l_sum[PW-1:16]);
    fb_r_rnd = $signed(fb_r_sum[PW-1:16]);
    fb_to_l  = ping_pong_q ? fb_r_rnd : fb_l_rnd;
    fb_to_r  = ping_pong_q ? fb_l_rnd : fb_r_rnd;

    wr_pair.left  = sat_sample(SAT_W'(fb_to_l) + SAT_W'(wr_in_l));
    wr_pair.right = sat_sample(SAT_W'(fb_to_r) + SAT_W'(wr_in_r));

    // Output mix of dry input and wet delayed sample
    out_l_sum = SUM_W'(s3_dry_l_q) + SUM_W'(s3_wet_l_q) + SUM_W'(32768);
    out_r_sum = SUM_W'(s3_dry_r_q) + SUM_W'(s3_wet_r_q) + SUM_W'(32768);
    out_pair.left  = sat_sample($signed(out_l_sum[SUM_W-1:16]));
    out_pair.right = sat_sample($signed(out_r_sum[SUM_W-1:16]));
  end

  // ---------------------------------------------------------------------------
  // Delay stores
  // ---------------------------------------------------------------------------
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [SW-1:0]     ram_wdata_l, ram_wdata_r;

  assign ram_we      = clr_active_q || pipe_we;
  assign ram_waddr   = clr_active_q ? clr_addr_q : s3_addr_q;
  assign ram_wdata_l = clr_active_q ? '0 : wr_pair.left;
  assign ram_wdata_r = clr_active_q ? '0 : wr_pair.right;

  spfd_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_DELAY)
  ) u_left_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata_l),
    .re_i    (s1_valid_q),
    .raddr_i (s1_addr_q),
    .rdata_o (rd_left)
  );

  spfd_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_DELAY)
  ) u_right_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata_r),
    .re_i    (s1_valid_q),
    .raddr_i (s1_addr_q),
    .rdata_o (rd_right)
  );

  // ---------------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------------
  spfd_pkg::pair_t m_pair;

  spfd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s3_valid_q),
    .data_i  (out_pair),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_pair)
  );

  assign m_axis_tdata = m_pair;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The two multiplier phases never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && s2_valid_q))
    else $error("multiplier bank claimed by two stages");

  // The second stage is filled only from a first-stage transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> $past(s1_valid_q))
    else $error("second stage filled without a first-stage transaction");

  // No store write from the pipeline during a clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clr_active_q && pipe_we))
    else $error("pipeline write collides with clearing pass");

  // Credit count never exceeds queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= spfd_pkg::CREDIT_W'(spfd_pkg::OUT_DEPTH))
    else $error("in-flight count beyond output queue depth");

  // A result is shown only while some transaction is outstanding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (inflight_q != '0))
    else $error("output valid without an outstanding transaction");

endmodule

>>> tb/sv/stereo_pingpong_feedback_delay_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the stereo ping-pong feedback delay, with its own delay-line predictor.
module stereo_pingpong_feedback_delay_tb;
  import spfd_pkg::*;

  // Small store depth keeps the clearing passes short
  localparam int unsigned TAP_DEPTH     = 1024;
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam longint      PAN_FULL      = 32768;
  localparam logic [SAMPLE_W-1:0] FULL_POS = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] FULL_NEG = 24'h800000;

  typedef enum logic {ROW_PAIR, ROW_WRITE} row_kind_e;
  typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} sink_mode_e;

  // One line of the directed stimulus
  typedef struct {
    row_kind_e        kind;
    cfg_idx_e         idx;
    logic [CFG_W-1:0] value;
    pair_t            stim;
    bit               typed;
    pair_t            want;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [2*SAMPLE_W-1:0] s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [2*SAMPLE_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr_i    = '0;
  logic [CFG_W-1:0]      cfg_data_i    = '0;

  // Predictor state: both delay lines, shared tap position and register copies
  logic signed [SAMPLE_W-1:0] line_l [TAP_DEPTH];
  logic signed [SAMPLE_W-1:0] line_r [TAP_DEPTH];
  int unsigned                tap_pos    = 0;
  logic [LEN_CFG_W-1:0]       len_reg    = DELAY_LENGTH_RST;
  logic [FB_W-1:0]            fb_reg     = FEEDBACK_GAIN_RST;
  logic [GAIN_W-1:0]          dry_reg    = GAIN_ONE;
  logic [GAIN_W-1:0]          wet_reg    = GAIN_ONE;
  logic                       bypass_reg = 1'b0;
  logic                       cross_reg  = 1'b0;
  logic signed [PAN_W-1:0]    pan_reg    = '0;

  pair_t     expected_pairs [$];
  stim_row_t directed_rows [$];

  int unsigned burst_left      = 0;
  int unsigned pairs_sent      = 0;
  int unsigned random_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned writes_done     = 0;
  int unsigned bypass_pairs    = 0;
  int unsigned crossed_pairs   = 0;
  int unsigned fail_count      = 0;
  int unsigned phase_items;
  int unsigned sink_left       = 0;
  int unsigned sink_phase      = 0;
  sink_mode_e  sink_mode       = SINK_OPEN;
  bit          settled         = 1'b1;
  bit          first_phase     = 1'b1;

  stereo_pingpong_feedback_delay #(
    .MAX_DELAY(TAP_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Round half up, then drop s fraction bits
  function automatic longint round_drop(longint v, int unsigned s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp24(longint v);
    if (v > longint'(8388607)) return FULL_POS;
    if (v < -longint'(8388608)) return FULL_NEG;
    return v[SAMPLE_W-1:0];
  endfunction

  // Advance the delay lines by one pair and return the output pair; a bypass pair clears the lines and passes through
  function automatic pair_t delay_line_step(pair_t x);
    pair_t       y;
    longint      l, r, dl, dr, wl, wr, fb, dry, wet, pan;
    int unsigned span;
    l = $signed(x.left);
    r = $signed(x.right);
    if (bypass_reg) begin
      foreach (line_l[i]) begin
        line_l[i] = '0;
        line_r[i] = '0;
      end
      return x;
    end
    fb   = longint'(fb_reg);
    dry  = (dry_reg > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(dry_reg);
    wet  = (wet_reg > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(wet_reg);
    span = len_reg;
    if (span == 0) span = 1;
    if (span > TAP_DEPTH) span = TAP_DEPTH;
    if (tap_pos >= span) tap_pos = 0;
    dl = $signed(line_l[tap_pos]);
    dr = $signed(line_r[tap_pos]);
    if (cross_reg) begin
      // Attenuate one side by the pan, then cross the feedback
      pan = $signed(pan_reg);
      if (pan > PAN_FULL) pan = PAN_FULL;
      if (pan < -PAN_FULL) pan = -PAN_FULL;
      wl = l;
      wr = r;
      if (pan < 0) wr = round_drop(r * (PAN_FULL + pan), 15);
      else if (pan > 0) wl = round_drop(l * (PAN_FULL - pan), 15);
      line_l[tap_pos] = clamp24(round_drop(fb * dr, 16) + wl);
      line_r[tap_pos] = clamp24(round_drop(fb * dl, 16) + wr);
    end else begin
      line_l[tap_pos] = clamp24(round_drop(fb * dl, 16) + l);
      line_r[tap_pos] = clamp24(round_drop(fb * dr, 16) + r);
    end
    tap_pos = (tap_pos + 1 >= span) ? 0 : tap_pos + 1;
    y.left  = clamp24(round_drop(dry * l + wet * dl, 16));
    y.right = clamp24(round_drop(dry * r + wet * dr, 16));
    return y;
  endfunction

  function automatic void add_write(cfg_idx_e idx, logic [CFG_W-1:0] v);
    stim_row_t row;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.value = v;
    row.stim  = '0;
    row.typed = 1'b0;
    row.want  = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_pair(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r, bit typed,
                                   logic [SAMPLE_W-1:0] wl, logic [SAMPLE_W-1:0] wr);
    stim_row_t row;
    row.kind  = ROW_PAIR;
    row.idx   = CFG_DELAY_LENGTH;
    row.value = '0;
    row.stim  = {r, l};
    row.typed = typed;
    row.want  = {wr, wl};
    directed_rows.push_back(row);
  endfunction

  // Directed stimulus; typed expectations only where the output equals the input
  function automatic void build_directed();
    // empty stores after reset: output follows input
    add_pair(FULL_POS,     FULL_NEG,     1'b1, FULL_POS,     FULL_NEG);
    add_pair(FULL_NEG,     FULL_POS,     1'b1, FULL_NEG,     FULL_POS);
    add_pair(24'h000000,   24'h000000,   1'b1, 24'h000000,   24'h000000);
    add_pair(24'hFFFFFF,   24'h000001,   1'b1, 24'hFFFFFF,   24'h000001);
    // short line, full feedback, saturating stores
    add_write(CFG_DELAY_LENGTH,  19'd7);
    add_write(CFG_FEEDBACK_GAIN, 19'h0FFFF);
    add_pair(FULL_POS,     FULL_POS,     1'b0, '0, '0);
    add_pair(FULL_NEG,     FULL_NEG,     1'b0, '0, '0);
    add_pair(24'h123456,   24'hEDCBA9,   1'b0, '0, '0);
    add_pair(24'h400000,   24'hC00000,   1'b0, '0, '0);
    add_pair(24'h000001,   24'hFFFFFF,   1'b0, '0, '0);
    add_pair(24'h0ABCDE,   24'h765432,   1'b0, '0, '0);
    // crossed feedback with full negative pan
    add_write(CFG_PING_PONG,  19'd1);
    add_write(CFG_PAN_AMOUNT, 19'h18000);
    add_pair(FULL_POS,     FULL_POS,     1'b0, '0, '0);
    add_pair(24'h200000,   FULL_NEG,     1'b0, '0, '0);
    // nearly full positive pan
    add_write(CFG_PAN_AMOUNT, 19'h07FFF);
    add_pair(FULL_POS,     FULL_NEG,     1'b0, '0, '0);
    add_pair(FULL_NEG,     24'h3FFFFF,   1'b0, '0, '0);
    // pan beyond minus one, then beyond plus one
    add_write(CFG_PAN_AMOUNT, 19'h10000);
    add_pair(24'h555555,   24'hAAAAAA,   1'b0, '0, '0);
    add_write(CFG_PAN_AMOUNT, 19'h0FFFF);
    add_pair(24'hAAAAAA,   24'h555555,   1'b0, '0, '0);
    add_write(CFG_PAN_AMOUNT, 19'h00000);
    add_pair(FULL_POS,     FULL_POS,     1'b0, '0, '0);
    // zero length shrinks the line below the position; dry above one, no wet
    add_write(CFG_DELAY_LENGTH, 19'd0);
    add_write(CFG_DRY_GAIN,     19'h1FFFF);
    add_write(CFG_WET_GAIN,     19'h00000);
    add_write(CFG_PING_PONG,    19'd0);
    add_pair(FULL_POS,     FULL_NEG,     1'b0, '0, '0);
    add_pair(24'h100000,   24'hF00000,   1'b0, '0, '0);
    // length beyond the store depth, no feedback, wet above one
    add_write(CFG_DELAY_LENGTH,  19'h7FFFF);
    add_write(CFG_FEEDBACK_GAIN, 19'h00000);
    add_write(CFG_WET_GAIN,      19'h1FFFF);
    add_pair(24'h7FFFF0,   24'h800010,   1'b0, '0, '0);
    // bypass passes input through and clears the lines
    add_write(CFG_BYPASS, 19'd1);
    add_pair(FULL_POS,     FULL_NEG,     1'b1, FULL_POS,     FULL_NEG);
    add_pair(24'h13579B,   24'hECA864,   1'b1, 24'h13579B,   24'hECA864);
    add_write(CFG_BYPASS,   19'd0);
    add_write(CFG_DRY_GAIN, 19'h10000);
    add_write(CFG_WET_GAIN, 19'h10000);
    add_pair(24'h2468AC,   24'hDB9753,   1'b1, 24'h2468AC,   24'hDB9753);
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0:       return FULL_POS;
      1:       return FULL_NEG;
      2, 3:    return SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] draw_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_W'(GAIN_ONE);
      2:       return 19'h1FFFF;
      3:       return CFG_W'($urandom_range(0, 131071));
      default: return CFG_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // Write one register and mirror it into the predictor
  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DELAY_LENGTH:  len_reg    = v[LEN_CFG_W-1:0];
      CFG_FEEDBACK_GAIN: fb_reg     = v[FB_W-1:0];
      CFG_DRY_GAIN:      dry_reg    = v[GAIN_W-1:0];
      CFG_WET_GAIN:      wet_reg    = v[GAIN_W-1:0];
      CFG_BYPASS:        bypass_reg = v[0];
      CFG_PING_PONG:     cross_reg  = v[0];
      CFG_PAN_AMOUNT:    pan_reg    = v[PAN_W-1:0];
      default: ;
    endcase
    writes_done++;
    @(posedge clk_i);
  endtask

  // Pick a new random setting; every register is written in the first phase
  task automatic shuffle_settings(bit write_all);
    logic [CFG_W-1:0] v;
    if (write_all || $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 9))
        0:       v = '0;
        1:       v = 19'd1;
        2:       v = CFG_W'(TAP_DEPTH);
        3:       v = CFG_W'($urandom_range(TAP_DEPTH + 1, 19'h7FFFF));
        4:       v = 19'h7FFFF;
        default: v = CFG_W'($urandom_range(2, 40));
      endcase
      write_reg(CFG_DELAY_LENGTH, v);
    end
    if (write_all || $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0:       v = '0;
        1:       v = 19'h0FFFF;
        2:       v = 19'h08000;
        default: v = CFG_W'($urandom_range(0, 65535));
      endcase
      write_reg(CFG_FEEDBACK_GAIN, v);
    end
    if (write_all || $urandom_range(0, 1) == 0) write_reg(CFG_DRY_GAIN, draw_gain());
    if (write_all || $urandom_range(0, 1) == 0) write_reg(CFG_WET_GAIN, draw_gain());
    if (write_all || $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 6))
        0:       v = 19'h08000;
        1:       v = 19'h18000;
        2:       v = 19'h0FFFF;
        3:       v = 19'h10000;
        4:       v = '0;
        default: v = CFG_W'($urandom_range(0, 19'h7FFFF));
      endcase
      write_reg(CFG_PAN_AMOUNT, v);
    end
    write_reg(CFG_PING_PONG, CFG_W'($urandom_range(0, 1)));
    write_reg(CFG_BYPASS, CFG_W'($urandom_range(0, 5) == 0));
  endtask

  // Offer one pair in bursts with random gaps; predict once the transaction is taken
  task automatic send_pair(pair_t stim, bit typed, pair_t want);
    pair_t predicted;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= stim;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    if (bypass_reg) bypass_pairs++;
    else if (cross_reg) crossed_pairs++;
    predicted = delay_line_step(stim);
    expected_pairs.push_back(typed ? want : predicted);
    pairs_sent++;
  endtask

  // Hold off the sender until every result is back, then let the pipeline settle
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_result(pair_t got);
    pair_t want;
    if (expected_pairs.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: result with nothing outstanding: left %h right %h",
                 $time, got.left, got.right);
      return;
    end
    want = expected_pairs.pop_front();
    results_checked++;
    if (got.left !== want.left || got.right !== want.right) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: result %0d: left exp %h got %h, right exp %h got %h", $time,
                 results_checked, want.left, got.left, want.right, got.right);
    end
  endtask

  // Receiver: check each output transaction and stall on a changing pattern
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (sink_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 2));
        sink_left = $urandom_range(16, 96);
      end else begin
        sink_left--;
      end
      sink_phase++;
      case (sink_mode)
        SINK_OPEN:   m_axis_tready <= 1'b1;
        SINK_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default:     m_axis_tready <= ((sink_phase % 24) >= 14);
      endcase
    end
  end

  // Main sequence: reset, directed rows, random phases, verdict
  initial begin
    foreach (line_l[i]) begin
      line_l[i] = '0;
      line_r[i] = '0;
    end
    build_directed();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_WRITE) begin
        if (!settled) drain_and_settle();
        settled = 1'b1;
        write_reg(directed_rows[k].idx, directed_rows[k].value);
      end else begin
        settled = 1'b0;
        send_pair(directed_rows[k].stim, directed_rows[k].typed, directed_rows[k].want);
      end
    end

    while (random_sent < RANDOM_ITEMS) begin
      drain_and_settle();
      shuffle_settings(first_phase);
      first_phase = 1'b0;
      phase_items = $urandom_range(8, 48);
      repeat (phase_items) begin
        send_pair({draw_sample(), draw_sample()}, 1'b0, '0);
        random_sent++;
      end
    end
    drain_and_settle();

    $display("covered %0d stereo pairs (%0d random) over %0d register writes",
             pairs_sent, random_sent, writes_done);
    $display("%0d pairs bypassed, %0d with crossed feedback, %0d outputs compared, %0d bad",
             bypass_pairs, crossed_pairs, results_checked, fail_count);
    if (fail_count == 0) begin
      $display("stereo_pingpong_feedback_delay_tb: done, clean");
    end else begin
      $display("stereo_pingpong_feedback_delay_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", expected_pairs.size());
    $display("stereo_pingpong_feedback_delay_tb: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
sv/spfd_pkg.sv
sv/spfd_ram.sv
sv/spfd_mul_bank.sv
sv/spfd_out_fifo.sv
sv/stereo_pingpong_feedback_delay.sv
tb/sv/stereo_pingpong_feedback_delay_tb.sv
